>>> rtl/hsc_pkg.sv
// Hamming SEC codec package: payload word types, operation codes, field
// widths and register map constants. No dependencies.

package hsc_pkg;

  // Field widths
  localparam int unsigned WORD_W = 63;  // code word / data word
  localparam int unsigned DATA_W = 57;  // data positions in a 63-bit code word
  localparam int unsigned LEN_W  = 6;   // code_length, data_length
  localparam int unsigned SYN_W  = 6;   // syndrome
  localparam int unsigned CBC_W  = 3;   // check bit count
  localparam int unsigned MODE_W = 2;

  // Configuration register map
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_CODE_LENGTH = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_DATA_LENGTH = 1'b1;

  localparam logic [LEN_W-1:0] CODE_LENGTH_RST = 6'd7;
  localparam logic [LEN_W-1:0] DATA_LENGTH_RST = 6'd4;

  // Operation codes; the spare code behaves as check
  typedef enum logic [MODE_W-1:0] {
    MODE_ENCODE = 2'd0,
    MODE_DECODE = 2'd1,
    MODE_CHECK  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [WORD_W-1:0] word;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_word;
    logic [CBC_W-1:0]  check_bit_count;
    logic [SYN_W-1:0]  syndrome;
    logic              valid_res;
    logic              corrected;
    logic              length_error;
  } out_word_t;

endpackage

>>> rtl/hsc_syndrome.sv
// Hamming syndrome: one XOR tree per check bit over a 63-bit word.
// Depends on hsc_pkg.

module hsc_syndrome (
  input  logic [hsc_pkg::WORD_W-1:0] word_i,
  output logic [hsc_pkg::SYN_W-1:0]  syndrome_o
);

  // Positions covered by check bit j: every position whose index has bit j set
  function automatic logic [hsc_pkg::WORD_W-1:0] cover_mask(input int unsigned j);
    logic [hsc_pkg::WORD_W-1:0] m;
    m = '0;
    for (int unsigned i = 1; i <= hsc_pkg::WORD_W; i++) begin
      m[i-1] = ((i >> j) & 1) != 0;
    end
    return m;
  endfunction

  for (genvar j = 0; j < hsc_pkg::SYN_W; j++) begin : g_par
    localparam logic [hsc_pkg::WORD_W-1:0] Cover = cover_mask(j);
    assign syndrome_o[j] = ^(word_i & Cover);
  end

endmodule

>>> rtl/hsc_core.sv
// Hamming SEC transform for one word: scatter/gather of data positions,
// parity, single-bit correction. Combinational. Depends on hsc_pkg, hsc_syndrome.

module hsc_core #(
  parameter int unsigned MAX_CODE_BITS = 63
) (
  input  logic [hsc_pkg::LEN_W-1:0] code_length_i,
  input  logic [hsc_pkg::LEN_W-1:0] data_length_i,
  input  hsc_pkg::in_word_t         in_word_i,
  output hsc_pkg::out_word_t        out_word_o
);

  // Number of bits needed to hold i; also counts the powers of two up to i
  function automatic int unsigned bit_len(input int unsigned i);
    int unsigned b;
    b = 0;
    for (int unsigned k = 0; k < 7; k++) begin
      if ((i >> k) != 0) b = k + 1;
    end
    return b;
  endfunction

  function automatic bit is_pow2(input int unsigned i);
    return (i != 0) && ((i & (i - 1)) == 0);
  endfunction

  logic [hsc_pkg::LEN_W-1:0]  n;
  logic [hsc_pkg::CBC_W-1:0]  r;
  logic [hsc_pkg::WORD_W-1:0] nmask;
  logic [hsc_pkg::WORD_W-1:0] w_masked;
  logic [hsc_pkg::WORD_W-1:0] scat;
  logic [hsc_pkg::WORD_W-1:0] enc_data;
  logic [hsc_pkg::WORD_W-1:0] par_vec;
  logic [hsc_pkg::WORD_W-1:0] syn_word;
  logic [hsc_pkg::WORD_W-1:0] flip_vec;
  logic [hsc_pkg::WORD_W-1:0] w_fixed;
  logic [hsc_pkg::DATA_W-1:0] gath;
  logic [hsc_pkg::SYN_W-1:0]  syn;
  logic                       len_bad;
  logic                       do_flip;

  // Effective code length, clamped to the build maximum
  assign n = (code_length_i > hsc_pkg::LEN_W'(MAX_CODE_BITS)) ?
             hsc_pkg::LEN_W'(MAX_CODE_BITS) : code_length_i;

  // Check bit count is the bit length of n
  always_comb begin
    r = '0;
    for (int unsigned b = 0; b < hsc_pkg::LEN_W; b++) begin
      if (n[b]) r = hsc_pkg::CBC_W'(b + 1);
    end
  end

  assign nmask    = ~({hsc_pkg::WORD_W{1'b1}} << n);
  assign w_masked = in_word_i.word & nmask;

  // Fixed wiring between data bit k and its non-power-of-two position
  for (genvar i = 1; i <= hsc_pkg::WORD_W; i++) begin : g_pos
    if (is_pow2(i)) begin : g_par
      assign scat[i-1] = 1'b0;
    end else begin : g_dat
      localparam int unsigned K = i - bit_len(i) - 1;
      assign scat[i-1] = in_word_i.word[K];
      assign gath[K]   = w_fixed[i-1];
    end
  end

  assign enc_data = scat & nmask;

  // One syndrome unit serves both directions
  assign syn_word = (in_word_i.mode == hsc_pkg::MODE_ENCODE) ? enc_data : w_masked;

  hsc_syndrome u_syn (
    .word_i     (syn_word),
    .syndrome_o (syn)
  );

  // Parity bits land on positions 1, 2, 4, ...
  always_comb begin
    par_vec = '0;
    for (int unsigned j = 0; j < hsc_pkg::SYN_W; j++) begin
      par_vec[(1 << j) - 1] = syn[j];
    end
  end

  // Correction only when the syndrome names a position inside the word
  assign do_flip  = (syn != '0) && (syn <= n);
  assign flip_vec = do_flip ? (hsc_pkg::WORD_W'(1) << (syn - hsc_pkg::SYN_W'(1))) : '0;
  assign w_fixed  = w_masked ^ flip_vec;

  assign len_bad = ({1'b0, data_length_i} + {4'b0, r}) != {1'b0, n};

  // Result selection by operation
  always_comb begin
    out_word_o                 = '0;
    out_word_o.check_bit_count = r;
    unique case (in_word_i.mode)
      hsc_pkg::MODE_ENCODE: begin
        out_word_o.length_error = len_bad;
        out_word_o.result_word  = len_bad ? '0 : (enc_data | par_vec);
      end
      hsc_pkg::MODE_DECODE: begin
        out_word_o.result_word = {{(hsc_pkg::WORD_W - hsc_pkg::DATA_W){1'b0}}, gath};
        out_word_o.syndrome    = syn;
        out_word_o.valid_res   = (syn == '0);
        out_word_o.corrected   = do_flip;
      end
      default: begin
        out_word_o.syndrome  = syn;
        out_word_o.valid_res = (syn == '0);
      end
    endcase
  end

endmodule

>>> rtl/hamming_sec_codec.sv
// Hamming SEC codec top level: APB configuration registers, input and
// result registers around the transform. Depends on hsc_pkg, hsc_core.

// One word is taken per clock cycle with no bubbles while in_stall_o is low.
// An accepted word sits in the input register while the whole encode, decode
// or check runs through a single pass of combinational logic, and its result
// is written to the result register once that register is free; out_valid_o
// comes from the result register. The result register lets a
// new word enter while the previous result is still stalled; in_stall_o only
// rises when both registers are full and the output is stalled. code_length
// (address 0) and data_length (address 4) reset to 7 and 4 and should only
// be written while no word is in flight.

module hamming_sec_codec #(
  parameter int unsigned MAX_CODE_BITS = 63
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hsc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hsc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hsc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  hsc_pkg::in_word_t              in_word_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output hsc_pkg::out_word_t             out_word_o
);

  logic [hsc_pkg::LEN_W-1:0]     code_length_q, code_length_d;
  logic [hsc_pkg::LEN_W-1:0]     data_length_q, data_length_d;
  logic [hsc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;

  logic                          s1_valid_q, s1_valid_d;
  hsc_pkg::in_word_t             s1_word_q;
  logic                          out_valid_q, out_valid_d;
  hsc_pkg::out_word_t            out_word_q;
  hsc_pkg::out_word_t            core_word;
  logic                          out_adv;
  logic                          in_acc;

  // Register file
  assign reg_idx = paddr[hsc_pkg::APB_ADDR_W-1 -: hsc_pkg::REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    code_length_d = code_length_q;
    data_length_d = data_length_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        hsc_pkg::REG_CODE_LENGTH: code_length_d = pwdata[hsc_pkg::LEN_W-1:0];
        hsc_pkg::REG_DATA_LENGTH: data_length_d = pwdata[hsc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hsc_pkg::REG_CODE_LENGTH:
        prdata = {{(hsc_pkg::APB_DATA_W - hsc_pkg::LEN_W){1'b0}}, code_length_q};
      hsc_pkg::REG_DATA_LENGTH:
        prdata = {{(hsc_pkg::APB_DATA_W - hsc_pkg::LEN_W){1'b0}}, data_length_q};
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_length_q <= hsc_pkg::CODE_LENGTH_RST;
      data_length_q <= hsc_pkg::DATA_LENGTH_RST;
    end else begin
      code_length_q <= code_length_d;
      data_length_q <= data_length_d;
    end
  end

  // Pipeline flow: result register frees when empty or taken
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_stall_o ? s1_valid_q : in_valid_i;
  assign out_valid_d = out_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) s1_word_q <= in_word_i;
    if (out_adv && s1_valid_q) out_word_q <= core_word;
  end

  hsc_core #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_core (
    .code_length_i (code_length_q),
    .data_length_i (data_length_q),
    .in_word_i     (s1_word_q),
    .out_word_o    (core_word)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> dv/hamming_sec_codec_test.sv
// Self-checking testbench for hamming_sec_codec: directed and random words, with a
// predictor of the encode, decode and check results and random stalls on both sides.
// Depends on hsc_pkg and the hamming_sec_codec RTL.

module hamming_sec_codec_test;

  localparam int unsigned MAX_CODE_BITS  = 63;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [hsc_pkg::APB_ADDR_W-1:0] ADDR_CODE_LENGTH = {hsc_pkg::REG_CODE_LENGTH, 2'b00};
  localparam logic [hsc_pkg::APB_ADDR_W-1:0] ADDR_DATA_LENGTH = {hsc_pkg::REG_DATA_LENGTH, 2'b00};
  // Spare operation code, handled as check
  localparam logic [hsc_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [hsc_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [hsc_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [hsc_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           in_valid = 1'b0;
  logic                           in_stall_o;
  hsc_pkg::in_word_t              in_word = '0;
  logic                           out_valid_o;
  logic                           out_stall = 1'b0;
  hsc_pkg::out_word_t             out_word_o;

  // Register copies used by the predictor
  logic [hsc_pkg::LEN_W-1:0] code_len_q = hsc_pkg::CODE_LENGTH_RST;
  logic [hsc_pkg::LEN_W-1:0] data_len_q = hsc_pkg::DATA_LENGTH_RST;

  hsc_pkg::out_word_t pending_results[$];
  int unsigned        tx_max_gap = 15;
  int unsigned        rx_max_gap = 15;
  int unsigned        errors = 0;
  int unsigned        quiet_cycles = 0;

  hamming_sec_codec #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_word_o (out_word_o)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Smallest r with 2^r >= n+1
  function automatic int unsigned parity_bit_count(int unsigned n);
    int unsigned r;
    r = 0;
    while (r < 7 && (1 << r) < n + 1) r++;
    return r;
  endfunction

  // Each set bit p of the syndrome marks an odd parity group
  function automatic int unsigned parity_syndrome(logic [hsc_pkg::WORD_W-1:0] w,
                                                  int unsigned n);
    int unsigned s;
    int unsigned p;
    logic        par;
    s = 0;
    for (int j = 0; j < 6; j++) begin
      p = 1 << j;
      if (p <= n) begin
        par = 1'b0;
        for (int unsigned i = 1; i <= n; i++)
          if ((i & p) != 0) par ^= w[i-1];
        if (par) s |= p;
      end
    end
    return s;
  endfunction

  function automatic hsc_pkg::out_word_t codec_result(logic [hsc_pkg::MODE_W-1:0] mode,
                                                      logic [hsc_pkg::WORD_W-1:0] word,
                                                      logic [hsc_pkg::LEN_W-1:0]  cl,
                                                      logic [hsc_pkg::LEN_W-1:0]  dl);
    int unsigned                n;
    int unsigned                r;
    int unsigned                k;
    int unsigned                syn;
    int unsigned                par_syn;
    logic [hsc_pkg::WORD_W-1:0] nmask;
    logic [hsc_pkg::WORD_W-1:0] w;
    logic [hsc_pkg::WORD_W-1:0] res;
    hsc_pkg::out_word_t         o;
    n       = (cl > MAX_CODE_BITS) ? MAX_CODE_BITS : cl;
    r       = parity_bit_count(n);
    nmask   = (n == 0) ? '0 : ({hsc_pkg::WORD_W{1'b1}} >> (hsc_pkg::WORD_W - n));
    w       = word & nmask;
    res     = '0;
    syn     = 0;
    k       = 0;
    o       = '0;
    case (mode)
      hsc_pkg::MODE_ENCODE: begin
        if (dl + r != n) begin
          o.length_error = 1'b1;
        end else begin
          // data bits, lowest first, into the non-power-of-two positions
          for (int unsigned i = 1; i <= n; i++) begin
            if ((i & (i - 1)) != 0) begin
              res[i-1] = word[k];
              k++;
            end
          end
          par_syn = parity_syndrome(res, n);
          for (int j = 0; j < 6; j++)
            if (par_syn[j]) res[(1 << j) - 1] = 1'b1;
        end
      end
      hsc_pkg::MODE_DECODE: begin
        syn         = parity_syndrome(w, n);
        o.valid_res = (syn == 0);
        // a syndrome pointing past the word flips nothing
        if (syn > 0 && syn <= n) begin
          w[syn-1]    = ~w[syn-1];
          o.corrected = 1'b1;
        end
        for (int unsigned i = 1; i <= n; i++) begin
          if ((i & (i - 1)) != 0) begin
            res[k] = w[i-1];
            k++;
          end
        end
      end
      default: begin
        // check, and the spare code
        syn         = parity_syndrome(w, n);
        o.valid_res = (syn == 0);
      end
    endcase
    o.result_word     = res;
    o.check_bit_count = r[hsc_pkg::CBC_W-1:0];
    o.syndrome        = syn[hsc_pkg::SYN_W-1:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int unsigned draw_gap(int unsigned max_gap);
    return (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
  endfunction

  function automatic logic [hsc_pkg::WORD_W-1:0] rand_word();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[hsc_pkg::WORD_W-1:0];
  endfunction

  // Well-formed code word for the current code length
  function automatic logic [hsc_pkg::WORD_W-1:0] clean_codeword(
      logic [hsc_pkg::WORD_W-1:0] data);
    int unsigned        n;
    hsc_pkg::out_word_t enc;
    n   = code_len_q;
    enc = codec_result(hsc_pkg::MODE_ENCODE, data, code_len_q,
                       hsc_pkg::LEN_W'(n - parity_bit_count(n)));
    return enc.result_word;
  endfunction

  // Code word with at most one flipped bit, sometimes with stray bits above n; now and then a random word instead
  function automatic logic [hsc_pkg::WORD_W-1:0] noisy_codeword();
    logic [hsc_pkg::WORD_W-1:0] w;
    logic [hsc_pkg::WORD_W-1:0] nmask;
    int unsigned                n;
    n     = code_len_q;
    nmask = (n == 0) ? '0 : ({hsc_pkg::WORD_W{1'b1}} >> (hsc_pkg::WORD_W - n));
    if ($urandom_range(0, 7) == 0) return rand_word();
    w = clean_codeword(rand_word());
    case ($urandom_range(0, 3))
      1, 2:    if (n > 0) w[$urandom_range(1, n) - 1] ^= 1'b1;
      3:       w[$urandom_range(1, hsc_pkg::WORD_W) - 1] ^= 1'b1;
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) w |= rand_word() & ~nmask;
    return w;
  endfunction

  // One input word; the prediction is queued when the word is taken
  task automatic send_word(input logic [hsc_pkg::MODE_W-1:0] mode,
                           input logic [hsc_pkg::WORD_W-1:0] word);
    int unsigned       gap;
    hsc_pkg::in_word_t item;
    gap       = draw_gap(tx_max_gap);
    item.mode = mode;
    item.word = word;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= item;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    pending_results.push_back(codec_result(mode, word, code_len_q, data_len_q));
  endtask

  // Drain the pipeline before touching the registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [hsc_pkg::APB_ADDR_W-1:0] addr,
                           input logic [hsc_pkg::APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_readback(input logic [hsc_pkg::APB_ADDR_W-1:0] addr,
                              input logic [hsc_pkg::LEN_W-1:0]      value);
    logic [hsc_pkg::APB_DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== hsc_pkg::APB_DATA_W'(value)) begin
      $display("%0t: register at %0d expected %h actual %h", $time, addr,
               hsc_pkg::APB_DATA_W'(value), rd);
      errors++;
    end
    @(posedge clk);
  endtask

  // Upper data bits are random; only the low six are kept
  task automatic set_lengths(input int unsigned cl, input int unsigned dl);
    wait_idle();
    apb_write(ADDR_CODE_LENGTH, {26'($urandom), hsc_pkg::LEN_W'(cl)});
    apb_write(ADDR_DATA_LENGTH, {26'($urandom), hsc_pkg::LEN_W'(dl)});
    code_len_q = hsc_pkg::LEN_W'(cl);
    data_len_q = hsc_pkg::LEN_W'(dl);
    reg_readback(ADDR_CODE_LENGTH, code_len_q);
    reg_readback(ADDR_DATA_LENGTH, data_len_q);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, checking, watchdog
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = draw_gap(rx_max_gap);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid_o !== 1'b1);
    end
  end

  always @(posedge clk) begin : check_results
    hsc_pkg::out_word_t want;
    hsc_pkg::out_word_t got;
    if (rst_n && out_valid_o === 1'b1 && !out_stall) begin
      got = out_word_o;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.result_word !== want.result_word) begin
          $display("%0t: result_word expected %h actual %h", $time,
                   want.result_word, got.result_word);
          errors++;
        end
        if (got.check_bit_count !== want.check_bit_count) begin
          $display("%0t: check_bit_count expected %0d actual %0d", $time,
                   want.check_bit_count, got.check_bit_count);
          errors++;
        end
        if (got.syndrome !== want.syndrome) begin
          $display("%0t: syndrome expected %0d actual %0d", $time,
                   want.syndrome, got.syndrome);
          errors++;
        end
        if (got.valid_res !== want.valid_res) begin
          $display("%0t: valid_res expected %b actual %b", $time,
                   want.valid_res, got.valid_res);
          errors++;
        end
        if (got.corrected !== want.corrected) begin
          $display("%0t: corrected expected %b actual %b", $time,
                   want.corrected, got.corrected);
          errors++;
        end
        if (got.length_error !== want.length_error) begin
          $display("%0t: length_error expected %b actual %b", $time,
                   want.length_error, got.length_error);
          errors++;
        end
      end
    end
  end

  // No word moving on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset lengths 7 and 4, then a few words on the default code
  task automatic test_register_reset();
    reg_readback(ADDR_CODE_LENGTH, hsc_pkg::CODE_LENGTH_RST);
    reg_readback(ADDR_DATA_LENGTH, hsc_pkg::DATA_LENGTH_RST);
    send_word(hsc_pkg::MODE_ENCODE, '0);
    send_word(hsc_pkg::MODE_ENCODE, '1);
    send_word(hsc_pkg::MODE_DECODE, clean_codeword(63'hB) ^ 63'h10);
    send_word(hsc_pkg::MODE_CHECK, clean_codeword(63'h6));
    send_word(MODE_SPARE, rand_word());
  endtask

  // Full-length code: all-zero and all-one words, errors at both ends
  task automatic test_full_length();
    set_lengths(63, 57);
    send_word(hsc_pkg::MODE_ENCODE, '1);
    send_word(hsc_pkg::MODE_ENCODE, '0);
    send_word(hsc_pkg::MODE_DECODE, clean_codeword('1) ^ (63'd1 << 62));
    send_word(hsc_pkg::MODE_DECODE, clean_codeword(rand_word()) ^ 63'd1);
    send_word(hsc_pkg::MODE_CHECK, '1);
    send_word(MODE_SPARE, clean_codeword(rand_word()));
  endtask

  // Zero and one bit codes, and a syndrome that points past the word
  task automatic test_short_codes();
    set_lengths(0, 0);
    send_word(hsc_pkg::MODE_ENCODE, rand_word());
    send_word(hsc_pkg::MODE_DECODE, rand_word());
    set_lengths(1, 0);
    send_word(hsc_pkg::MODE_ENCODE, '1);
    send_word(hsc_pkg::MODE_DECODE, 63'd1);
    set_lengths(5, 2);
    send_word(hsc_pkg::MODE_DECODE, 63'h0B);
    send_word(hsc_pkg::MODE_DECODE, 63'h0A);
    send_word(hsc_pkg::MODE_CHECK, 63'h0B | (63'h5 << 40));
  endtask

  // Data length that does not fit the code length
  task automatic test_length_errors();
    set_lengths(0, 1);
    send_word(hsc_pkg::MODE_ENCODE, rand_word());
    set_lengths(7, 5);
    send_word(hsc_pkg::MODE_ENCODE, '1);
    set_lengths(63, 63);
    send_word(hsc_pkg::MODE_ENCODE, '1);
  endtask

  // Phases of random lengths, modes and handshake pressure
  task automatic test_random_traffic();
    int unsigned cl;
    int unsigned dl;
    int unsigned sel;
    for (int phase = 0; phase < 17; phase++) begin
      case (phase)
        0:       cl = 63;
        1:       cl = 0;
        2:       cl = 1;
        3:       cl = 3;
        default: cl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 63);
      endcase
      if ($urandom_range(0, 3) == 0) dl = $urandom_range(0, 63);
      else dl = cl - parity_bit_count(cl);
      set_lengths(cl, dl);
      case (phase % 4)
        0: begin tx_max_gap = 15; rx_max_gap = 15; end
        1: begin tx_max_gap = 0;  rx_max_gap = 0;  end
        2: begin tx_max_gap = 0;  rx_max_gap = 15; end
        3: begin tx_max_gap = 15; rx_max_gap = 0;  end
      endcase
      for (int i = 0; i < 100; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 35)      send_word(hsc_pkg::MODE_ENCODE, rand_word());
        else if (sel < 75) send_word(hsc_pkg::MODE_DECODE, noisy_codeword());
        else if (sel < 95) send_word(hsc_pkg::MODE_CHECK, noisy_codeword());
        else               send_word(MODE_SPARE, noisy_codeword());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_register_reset();
    test_full_length();
    test_short_codes();
    test_length_errors();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/hsc_pkg.sv
rtl/hsc_syndrome.sv
rtl/hsc_core.sv
rtl/hamming_sec_codec.sv
dv/hamming_sec_codec_test.sv
